@@ hw/rtl/prrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg
// types and constants shared by the priority round-robin scheduler
// ----------------------------------------------------------------------------
package prrs_pkg;

    localparam int MAX_TASKS     = 64;
    localparam int NUM_LEVELS    = 8;
    localparam int TASK_W        = 6;
    localparam int LVL_W         = 3;
    localparam int PRIO_W        = 3;
    localparam int QUANT_W       = 8;
    localparam int STEP_W        = 6;
    localparam int LVL_TOP       = NUM_LEVELS - 1;
    localparam int QUANT_RESET   = 5;

    typedef logic [TASK_W-1:0]  t_task;
    typedef logic [LVL_W-1:0]   t_lvl;
    typedef logic [QUANT_W-1:0] t_quant;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_YIELD  = 2'd3
    } t_op;

    localparam logic [1:0] ST_RUNNING    = 2'd0;
    localparam logic [1:0] ST_TERMINATED = 2'd2;

    localparam logic [1:0] CFG_SCHED_ON     = 2'd0;
    localparam logic [1:0] CFG_QUANTUM_LEN  = 2'd1;
    localparam logic [1:0] CFG_IDLE_TASK    = 2'd2;
    localparam logic [1:0] CFG_IDLE_PRESENT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_POP_SEL,
        S_POP,
        S_RM_LVL,
        S_WALK,
        S_DONE
    } t_state;

    function automatic t_lvl clamp_level(input logic [PRIO_W-1:0] p);
        if (int'(p) > LVL_TOP) begin
            return t_lvl'(LVL_TOP);
        end
        return t_lvl'(p);
    endfunction

endpackage

@@ hw/rtl/priority_round_robin_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_unit
// multilevel priority round-robin task scheduler with linked ready lists
// ----------------------------------------------------------------------------
// One transaction in gives one result transaction out. Each priority level
// holds a fifo ready list linked through a per-task next pointer kept in a
// synchronous ram; task levels sit in a second ram. An add is done in the
// decode state; a tick or yield may read the level for the requeue, then
// the link for the pop; a remove reads the level, then walks the list up
// to the target, following the link ram one read per entry walked. A new
// transaction is taken once the previous one has been placed in the output
// register, so one result may wait there while the next operation runs.
// The rams need no clearing after reset.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_unit
    import prrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // operation channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [TASK_W-1:0] i_task_id,
    input  logic [PRIO_W-1:0] i_task_priority,
    input  logic [1:0]        i_current_status,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [TASK_W-1:0] o_running_task,
    output logic              o_running_valid,
    output logic              o_switch_needed,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    // state machine and latched transaction
    t_state r_state, n_state;
    t_op    r_op;
    t_task  r_id;
    t_lvl   r_prio;
    logic [1:0] r_status;

    // configuration registers
    logic   r_sched_on;
    t_quant r_quantum_len;
    t_task  r_idle_task;
    logic   r_idle_present;

    // scheduler state held in flops
    logic [MAX_TASKS-1:0]  r_queued, n_queued;
    t_task                 r_head [NUM_LEVELS];
    t_task                 n_head [NUM_LEVELS];
    t_task                 r_tail [NUM_LEVELS];
    t_task                 n_tail [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_lvl_valid, n_lvl_valid;
    t_task  r_cur, n_cur;
    logic   r_cur_v, n_cur_v;
    t_quant r_q, n_q;

    // working registers of the multi-cycle operations
    t_lvl  r_lvl, n_lvl;
    t_task r_walk_cur, n_walk_cur;
    t_task r_walk_prev, n_walk_prev;
    logic  r_have_prev, n_have_prev;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic  r_idle_fb, n_idle_fb;
    t_task r_old_cur;
    logic  r_old_v;

    // output register
    logic  r_out_valid;
    t_task r_out_task;
    logic  r_out_rv;
    logic  r_out_sw;

    // link and level rams, one read and one write port each
    t_task m_link  [MAX_TASKS];
    t_lvl  m_level [MAX_TASKS];
    t_task r_link_q;
    t_lvl  r_level_q;
    logic  link_we, link_re, level_we, level_re;
    t_task link_waddr, link_wdata, link_raddr, level_waddr, level_raddr;
    t_lvl  level_wdata;

    // lowest-numbered nonempty level
    logic  pick_found;
    t_lvl  pick_lvl;

    logic  in_acc;
    logic  done_load;
    t_quant q_dec;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign done_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign q_dec       = (r_q != '0) ? r_q - t_quant'(1) : r_q;

    always_comb begin
        pick_found = 1'b0;
        pick_lvl   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_lvl_valid[l]) begin
                pick_found = 1'b1;
                pick_lvl   = t_lvl'(l);
            end
        end
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_queued    = r_queued;
        n_head      = r_head;
        n_tail      = r_tail;
        n_lvl_valid = r_lvl_valid;
        n_cur       = r_cur;
        n_cur_v     = r_cur_v;
        n_q         = r_q;
        n_lvl       = r_lvl;
        n_walk_cur  = r_walk_cur;
        n_walk_prev = r_walk_prev;
        n_have_prev = r_have_prev;
        n_steps     = r_steps;
        n_idle_fb   = r_idle_fb;
        link_we     = 1'b0;
        link_waddr  = '0;
        link_wdata  = '0;
        link_re     = 1'b0;
        link_raddr  = '0;
        level_we    = 1'b0;
        level_waddr = '0;
        level_wdata = '0;
        level_re    = 1'b0;
        level_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_ADD: begin
                        if (!r_queued[r_id] && !(r_cur_v && r_cur == r_id)) begin
                            level_we    = 1'b1;
                            level_waddr = r_id;
                            level_wdata = r_prio;
                            if (r_sched_on && !r_cur_v) begin
                                n_cur   = r_id;
                                n_cur_v = 1'b1;
                                n_q     = r_quantum_len;
                            end else begin
                                // append at the tail of its level
                                if (r_lvl_valid[r_prio]) begin
                                    link_we    = 1'b1;
                                    link_waddr = r_tail[r_prio];
                                    link_wdata = r_id;
                                end else begin
                                    n_head[r_prio]      = r_id;
                                    n_lvl_valid[r_prio] = 1'b1;
                                end
                                n_tail[r_prio]   = r_id;
                                n_queued[r_id]   = 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (r_cur_v && r_cur == r_id) begin
                            n_cur_v = 1'b0;
                            n_cur   = '0;
                            n_q     = '0;
                        end
                        if (r_queued[r_id]) begin
                            level_re    = 1'b1;
                            level_raddr = r_id;
                            n_state     = S_RM_LVL;
                        end
                    end
                    default: begin
                        // tick and yield
                        if (r_sched_on) begin
                            if (r_op == OP_TICK && !r_cur_v) begin
                                n_idle_fb = 1'b1;
                                n_state   = S_POP_SEL;
                            end else if (r_op == OP_TICK && r_status != ST_TERMINATED
                                         && q_dec != '0) begin
                                n_q = q_dec;
                            end else begin
                                if (r_op == OP_TICK) begin
                                    n_q = q_dec;
                                end
                                n_idle_fb = 1'b0;
                                if (r_cur_v && r_status == ST_RUNNING
                                    && !r_queued[r_cur]) begin
                                    level_re    = 1'b1;
                                    level_raddr = r_cur;
                                    n_state     = S_PUSH;
                                end else begin
                                    n_state = S_POP_SEL;
                                end
                            end
                        end
                    end
                endcase
            end

            S_PUSH: begin
                // requeue the current task at its own level
                n_lvl = r_level_q;
                if (r_lvl_valid[r_level_q]) begin
                    link_we    = 1'b1;
                    link_waddr = r_tail[r_level_q];
                    link_wdata = r_cur;
                end else begin
                    n_head[r_level_q]      = r_cur;
                    n_lvl_valid[r_level_q] = 1'b1;
                end
                n_tail[r_level_q] = r_cur;
                n_queued[r_cur]   = 1'b1;
                n_state           = S_POP_SEL;
            end

            S_POP_SEL: begin
                n_state = S_DONE;
                if (pick_found) begin
                    n_lvl = pick_lvl;
                    if (r_tail[pick_lvl] == r_head[pick_lvl]) begin
                        // single entry, list empties
                        n_lvl_valid[pick_lvl]       = 1'b0;
                        n_queued[r_head[pick_lvl]]  = 1'b0;
                        n_cur                       = r_head[pick_lvl];
                        n_cur_v                     = 1'b1;
                        n_q                         = r_quantum_len;
                    end else begin
                        link_re    = 1'b1;
                        link_raddr = r_head[pick_lvl];
                        n_state    = S_POP;
                    end
                end else if (r_idle_fb) begin
                    if (r_idle_present) begin
                        n_cur   = r_idle_task;
                        n_cur_v = 1'b1;
                        n_q     = r_quantum_len;
                    end
                end else begin
                    n_cur_v = 1'b0;
                    n_cur   = '0;
                end
            end

            S_POP: begin
                n_head[r_lvl]           = r_link_q;
                n_queued[r_head[r_lvl]] = 1'b0;
                n_cur                   = r_head[r_lvl];
                n_cur_v                 = 1'b1;
                n_q                     = r_quantum_len;
                n_state                 = S_DONE;
            end

            S_RM_LVL: begin
                n_lvl = r_level_q;
                if (r_lvl_valid[r_level_q]) begin
                    n_walk_cur  = r_head[r_level_q];
                    n_have_prev = 1'b0;
                    n_steps     = '0;
                    link_re     = 1'b1;
                    link_raddr  = r_head[r_level_q];
                    n_state     = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_WALK: begin
                // r_link_q holds the successor of r_walk_cur
                if (r_walk_cur == r_id) begin
                    if (r_tail[r_lvl] == r_walk_cur) begin
                        if (r_have_prev) begin
                            n_tail[r_lvl] = r_walk_prev;
                        end else begin
                            n_lvl_valid[r_lvl] = 1'b0;
                        end
                    end else if (r_have_prev) begin
                        link_we    = 1'b1;
                        link_waddr = r_walk_prev;
                        link_wdata = r_link_q;
                    end else begin
                        n_head[r_lvl] = r_link_q;
                    end
                    n_queued[r_id] = 1'b0;
                    n_state        = S_DONE;
                end else if (r_tail[r_lvl] == r_walk_cur
                             || r_steps == STEP_W'(MAX_TASKS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_walk_prev = r_walk_cur;
                    n_have_prev = 1'b1;
                    n_walk_cur  = r_link_q;
                    n_steps     = r_steps + STEP_W'(1);
                    link_re     = 1'b1;
                    link_raddr  = r_link_q;
                end
            end

            S_DONE: begin
                if (done_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued       <= '0;
            r_lvl_valid    <= '0;
            r_cur          <= '0;
            r_cur_v        <= 1'b0;
            r_q            <= '0;
            r_out_valid    <= 1'b0;
            r_sched_on     <= 1'b0;
            r_quantum_len  <= t_quant'(QUANT_RESET);
            r_idle_task    <= '0;
            r_idle_present <= 1'b1;
        end else begin
            r_queued    <= n_queued;
            r_lvl_valid <= n_lvl_valid;
            r_cur       <= n_cur;
            r_cur_v     <= n_cur_v;
            r_q         <= n_q;
            if (done_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCHED_ON:     r_sched_on     <= i_cfg_data[0];
                    CFG_QUANTUM_LEN:  r_quantum_len  <= i_cfg_data;
                    CFG_IDLE_TASK:    r_idle_task    <= i_cfg_data[TASK_W-1:0];
                    CFG_IDLE_PRESENT: r_idle_present <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_lvl       <= n_lvl;
        r_walk_cur  <= n_walk_cur;
        r_walk_prev <= n_walk_prev;
        r_have_prev <= n_have_prev;
        r_steps     <= n_steps;
        r_idle_fb   <= n_idle_fb;
        if (in_acc) begin
            r_op      <= t_op'(i_operation);
            r_id      <= i_task_id;
            r_prio    <= clamp_level(i_task_priority);
            r_status  <= i_current_status;
            r_old_cur <= r_cur;
            r_old_v   <= r_cur_v;
        end
        if (done_load) begin
            r_out_task <= r_cur_v ? r_cur : '0;
            r_out_rv   <= r_cur_v;
            r_out_sw   <= r_cur_v && (!r_old_v || r_old_cur != r_cur);
        end
    end

    // link and level rams
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            m_link[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_q <= m_link[link_raddr];
        end
        if (level_we) begin
            m_level[level_waddr] <= level_wdata;
        end
        if (level_re) begin
            r_level_q <= m_level[level_raddr];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_running_task  = r_out_task;
    assign o_running_valid = r_out_rv;
    assign o_switch_needed = r_out_sw;

endmodule
